// ----- sv/bd2a_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII formatter.
package bd2a_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Double dabble correction: a BCD digit at or above five gets three added before the shift.
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;

endpackage

// ----- sv/binary_to_decimal_ascii.sv -----
// Top level: formats a binary word as decimal ASCII text, one character per transaction.
// Flow: an accepted word takes one shift and add-3 pass per input bit in the double dabble
//   unit, then the digits are handed over, suppressed leading zeros are skipped and the sign,
//   if any, comes before the first digit. An output stall holds the current character.
// Input: a new word is taken only in idle, after the last character of the previous word.
// Reset: rst is synchronous, active high; it drops any word in flight and returns to idle.
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
  input  logic                                s_axis_tuser,  // is_signed
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // character
  output logic                                m_axis_tlast   // last_char
);

  // Decimal digits needed for the largest VALUE_BITS-bit magnitude.
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int RW   = $clog2(NDIG + 1);

  bd2a_pkg::state_t state, state_next;

  logic                  in_acc;
  logic                  out_acc;
  logic [VALUE_BITS-1:0] raw;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  core_done;
  logic [NDIG*4-1:0]     core_bcd;

  logic                  neg;
  logic [NDIG*4-1:0]     dig;
  logic [RW-1:0]         remain;
  logic [3:0]            top_dig;
  logic                  skip_zero;
  logic                  last_dig;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Take the magnitude; the most negative value wraps to its exact unsigned magnitude.
  assign raw    = s_axis_tdata[VALUE_BITS-1:0];
  assign in_neg = s_axis_tuser & raw[VALUE_BITS-1];
  assign mag    = in_neg ? (~raw + 1'b1) : raw;

  bd2a_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .mag   (mag),
    .done  (core_done),
    .bcd   (core_bcd)
  );

  assign top_dig   = dig[NDIG*4-1 -: 4];
  // Drop leading zeros but always keep the final digit, so zero prints as "0".
  assign skip_zero = (top_dig == 4'd0) && (remain != RW'(1));
  assign last_dig  = (remain == RW'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bd2a_pkg::ST_IDLE: begin
        if (in_acc) state_next = bd2a_pkg::ST_CONV;
      end
      bd2a_pkg::ST_CONV: begin
        if (core_done) state_next = bd2a_pkg::ST_SKIP;
      end
      bd2a_pkg::ST_SKIP: begin
        if (!skip_zero) state_next = neg ? bd2a_pkg::ST_SIGN : bd2a_pkg::ST_DIGIT;
      end
      bd2a_pkg::ST_SIGN: begin
        if (m_axis_tready) state_next = bd2a_pkg::ST_DIGIT;
      end
      bd2a_pkg::ST_DIGIT: begin
        if (m_axis_tready && last_dig) state_next = bd2a_pkg::ST_IDLE;
      end
      default: state_next = bd2a_pkg::ST_IDLE;
    endcase
  end

  // Outputs, all from registered state and digits.
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tdata  = bd2a_pkg::ASCII_ZERO + {4'd0, top_dig};
    m_axis_tlast  = 1'b0;
    case (state)
      bd2a_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      bd2a_pkg::ST_SIGN: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = bd2a_pkg::ASCII_MINUS;
      end
      bd2a_pkg::ST_DIGIT: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast  = last_dig;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bd2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit register: load from the dabble unit, then advance one digit per skip or send.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg <= in_neg;
    end
    if (state == bd2a_pkg::ST_CONV && core_done) begin
      dig    <= core_bcd;
      remain <= RW'(NDIG);
    end else if ((state == bd2a_pkg::ST_SKIP && skip_zero) ||
                 (state == bd2a_pkg::ST_DIGIT && out_acc)) begin
      dig    <= {dig[NDIG*4-5:0], 4'd0};
      remain <= remain - 1'b1;
    end
  end

endmodule

// ----- sv/bd2a_dabble.sv -----
// Iterative double dabble unit: one shift and add-3 pass per input bit.
module bd2a_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_BITS-1:0]  mag,
  output logic                   done,
  output logic [NDIG*4-1:0]      bcd
);

  localparam int CW = $clog2(VALUE_BITS);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [VALUE_BITS-1:0] bin;
  logic [NDIG*4-1:0] bcd_adj;

  // Correct every digit in parallel before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= bd2a_pkg::BCD_ADJ_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + bd2a_pkg::BCD_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      {bcd, bin} <= {bcd_adj, bin} << 1;
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the binary to decimal ASCII formatter.
module testbench;

  localparam int VALUE_BITS   = 32;
  localparam int DATA_BITS    = ((VALUE_BITS + 7) / 8) * 8;
  localparam int TEXT_CHARS   = 11;              // sign plus ten digits
  localparam int RANDOM_ITEMS = 292;
  localparam int STALL_LIMIT  = 2000;            // cycles with no transaction on either side
  localparam int TAIL_CYCLES  = 200;             // idle time allowed after the drain for stray characters
  localparam int NUM_DIRECTED = 20;

  // One directed row: the word, its flag, and the text it must produce.
  // An all-zero text means the row is checked against the predictor instead.
  typedef struct packed {
    logic [VALUE_BITS-1:0]   value;
    logic                    is_signed;
    logic [8*TEXT_CHARS-1:0] text;
  } dir_row_t;

  // One queued input word; hold_for_drain stalls the sender until the
  // formatter has delivered every character still owed.
  typedef struct packed {
    logic [VALUE_BITS-1:0]   value;
    logic                    is_signed;
    logic [8*TEXT_CHARS-1:0] text;
    logic                    hold_for_drain;
  } word_item_t;

  // One expected output character.
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } dec_char_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b0, "0"},
    '{32'h0000_0000, 1'b1, "0"},
    '{32'hFFFF_FFFF, 1'b0, "4294967295"},
    '{32'hFFFF_FFFF, 1'b1, "-1"},
    '{32'h8000_0000, 1'b1, "-2147483648"},
    '{32'h8000_0000, 1'b0, "2147483648"},
    '{32'h7FFF_FFFF, 1'b1, "2147483647"},
    '{32'h7FFF_FFFF, 1'b0, "2147483647"},
    '{32'h0000_0001, 1'b1, "1"},
    '{32'h0000_0009, 1'b0, "9"},
    '{32'h0000_000A, 1'b0, "10"},
    '{32'hFFFF_FFF6, 1'b1, "-10"},
    '{32'd1000000000, 1'b0, "1000000000"},
    '{32'd999999999, 1'b1, "999999999"},
    '{32'h8000_0001, 1'b1, 88'h0},
    '{32'hAAAA_AAAA, 1'b1, 88'h0},
    '{32'hAAAA_AAAA, 1'b0, 88'h0},
    '{32'h5555_5555, 1'b1, 88'h0},
    '{32'h0000_0064, 1'b0, 88'h0},
    '{32'hFFFF_FF9C, 1'b1, 88'h0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_BITS-1:0] s_axis_tdata = '0;   // value
  logic                 s_axis_tuser = 1'b0;  // is_signed
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // character
  logic                 m_axis_tlast;         // last_char

  word_item_t word_queue[$];
  dec_char_t  expected_chars[$];
  int         total_words;
  int         accepted_words = 0;
  int         chars_seen = 0;
  int         stall_cycles = 0;
  int         error_count = 0;

  binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("ERROR: char %0d: %s: got 'h%02h, expected 'h%02h", chars_seen, what, got, want);
  endtask

  // Predict the decimal text of one word: sign for negative signed input,
  // then digits most significant first with leading zeros dropped.
  task automatic queue_decimal(input logic [VALUE_BITS-1:0] value, input logic is_signed);
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digits [20];
    int                    num_digits;
    logic                  negative;
    dec_char_t             c;
    negative = is_signed && value[VALUE_BITS-1];
    // Two's complement negate; the most negative word wraps to its own exact magnitude.
    magnitude = negative ? (~value + 1'b1) : value;
    num_digits = 0;
    // Always take at least one digit so that zero yields "0".
    do begin
      digits[num_digits] = 4'(magnitude % 10);
      num_digits++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      c.character = bd2a_pkg::ASCII_MINUS;
      c.last_char = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      c.character = bd2a_pkg::ASCII_ZERO + {4'd0, digits[k]};
      c.last_char = (k == 0);
      expected_chars.push_back(c);
    end
  endtask

  // Queue the typed-in text of a directed row, right-justified in its field.
  task automatic queue_text(input logic [8*TEXT_CHARS-1:0] text);
    dec_char_t c;
    for (int b = TEXT_CHARS - 1; b >= 0; b--) begin
      if (text[b*8 +: 8] != 8'h00) begin
        c.character = text[b*8 +: 8];
        c.last_char = (b == 0);
        expected_chars.push_back(c);
      end
    end
  endtask

  // Draw a random word, biased toward digit-count changes and sign boundaries.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] p;
    p = VALUE_BITS'(1);
    case ($urandom_range(7))
      3: begin
        // one either side of a power of ten
        repeat ($urandom_range(9)) p = p * 10;
        return p + VALUE_BITS'($urandom_range(2)) - 1'b1;
      end
      4: begin
        // negative powers of ten, read as signed they shorten by a digit
        repeat ($urandom_range(9)) p = p * 10;
        return ~p + VALUE_BITS'($urandom_range(2));
      end
      5: begin
        case ($urandom_range(2))
          0: return 32'h8000_0000 + VALUE_BITS'($urandom_range(3));
          1: return 32'h7FFF_FFFF - VALUE_BITS'($urandom_range(3));
          default: return 32'hFFFF_FFFF - VALUE_BITS'($urandom_range(3));
        endcase
      end
      6: return VALUE_BITS'($urandom()) >> $urandom_range(VALUE_BITS - 1);
      7: return VALUE_BITS'($urandom_range(999));
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // Build the stimulus: directed rows first, then random words.
  initial begin
    word_item_t item;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      item.value          = DIRECTED_ROWS[i].value;
      item.is_signed      = DIRECTED_ROWS[i].is_signed;
      item.text           = DIRECTED_ROWS[i].text;
      item.hold_for_drain = 1'b0;
      word_queue.push_back(item);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      item.value          = pick_value();
      item.is_signed      = 1'($urandom_range(1));
      item.text           = '0;
      // Starve the input a couple of times until every owed character is out.
      item.hold_for_drain = (i == 120) || (i == 240);
      word_queue.push_back(item);
    end
    total_words = word_queue.size();
  end

  // Check, predict and drive in one process so that the edge ordering is fixed.
  always @(posedge clk) begin
    int        sender_idle;
    int        receiver_idle;
    dec_char_t want;
    word_item_t done_item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      // Pick the idling mix for this third of the run.
      if (accepted_words < total_words / 3) begin
        sender_idle   = 15;
        receiver_idle = 73;
      end else if (accepted_words < (2 * total_words) / 3) begin
        sender_idle   = 73;
        receiver_idle = 15;
      end else begin
        sender_idle   = 0;
        receiver_idle = 0;
      end

      // Compare an output transaction against the oldest owed character.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character", m_axis_tdata, 8'h00);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.character)
            report_mismatch("character", m_axis_tdata, want.character);
          if (m_axis_tlast !== want.last_char)
            report_mismatch("last_char", {7'd0, m_axis_tlast}, {7'd0, want.last_char});
        end
        chars_seen++;
      end

      // Retire an input transaction and queue what it must produce.
      if (s_axis_tvalid && s_axis_tready) begin
        done_item = word_queue.pop_front();
        if (done_item.text != '0) begin
          queue_text(done_item.text);
        end else begin
          queue_decimal(done_item.value, done_item.is_signed);
        end
        accepted_words++;
      end

      // Watchdog: count cycles with no transaction on either side.
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end

      // Sender: hold a pending word, otherwise offer the next one or idle.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_queue.size() != 0 &&
            !(word_queue[0].hold_for_drain && expected_chars.size() != 0) &&
            ($urandom_range(99) >= sender_idle)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= DATA_BITS'(word_queue[0].value);
          s_axis_tuser  <= word_queue[0].is_signed;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      // Receiver: stall at random per the current mix.
      m_axis_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // Sequence the run: reset, drain, settle, then report.
  initial begin
    int tail;
    bit timed_out;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Sample mid-cycle so that the drive process has settled.
    @(negedge clk);
    while ((word_queue.size() != 0 || s_axis_tvalid || expected_chars.size() != 0) &&
           stall_cycles < STALL_LIMIT)
      @(negedge clk);
    // Let any stray character show up before declaring the run clean.
    tail = 0;
    while (tail < TAIL_CYCLES && stall_cycles < STALL_LIMIT) begin
      @(negedge clk);
      tail++;
    end
    timed_out = (stall_cycles >= STALL_LIMIT);
    if (timed_out) begin
      $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
      $display("binary_to_decimal_ascii: mismatch");
    end else if (error_count == 0) begin
      $display("binary_to_decimal_ascii: match");
    end else begin
      $display("binary_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
